FILE: hw/rtl/fzt_pkg.sv
// ============================================================================
// fzt_pkg
// Shared widths, rule table, grading functions and divider cell beat type
// for the fuzzy tracker drive.
// ============================================================================
package fzt_pkg;

    localparam int LEVEL_W     = 7;
    localparam int GRADE_W     = 9;                  // Q1.8, 0..256
    localparam int MAG_W       = 12;                 // 5*r + 1280, up to 2560
    localparam int PROD_W      = 20;                 // r * mag, up to 655360
    localparam int NUM_W       = 24;                 // signed sum of nine products
    localparam int DEN_W       = 12;                 // sum of nine weights, up to 2304
    localparam int Q_W         = 12;                 // quotient magnitude, up to 2560
    localparam int REM_W       = 23;                 // |num| + den/2
    localparam int DSH_W       = DEN_W + Q_W - 1;    // divisor aligned to top quotient bit
    localparam int DRIVE_W     = 13;
    localparam int N_GRADES    = 3;
    localparam int N_RULES     = N_GRADES * N_GRADES;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int ONE_Q8      = 256;
    localparam int MAG_BASE    = 5 * ONE_Q8;
    localparam int MAG_SLOPE   = 5;
    localparam int RECIP_10    = 52429;              // ceil(2^19 / 10)
    localparam int RECIP_SH_10 = 19;
    localparam int RECIP_SH_20 = 20;

    typedef enum logic [1:0]
    {
        ACT_OFF,
        ACT_CW,
        ACT_CCW
    } action_t;

    // [top grade][bottom grade], grades ordered dark, normal, bright
    localparam action_t RULE_ACTION [N_GRADES][N_GRADES] = '{
        '{ACT_OFF, ACT_CCW, ACT_CCW},
        '{ACT_CW,  ACT_OFF, ACT_CCW},
        '{ACT_CW,  ACT_CW,  ACT_OFF}
    };

    typedef logic [GRADE_W-1:0] grade_t;

    // One beat travelling down the divider row
    typedef struct packed
    {
        logic               valid;
        logic               zero;   // total weight was zero
        logic               neg;    // sign of the numerator
        logic [REM_W-1:0]   rem;
        logic [DSH_W-1:0]   dsh;
        logic [Q_W-1:0]     quo;
    } cell_t;

    // floor(n/10) by reciprocal multiply, exact for 0 <= n < 40000
    function automatic int div_by_10(input int n);
        return (n * RECIP_10) >> RECIP_SH_10;
    endfunction

    // floor(n/20), same reciprocal one place further down
    function automatic int div_by_20(input int n);
        return (n * RECIP_10) >> RECIP_SH_20;
    endfunction

    function automatic grade_t grade_dark(input logic [LEVEL_W-1:0] x);
        int xi;
        xi = int'(x);
        if (xi <= 30)
            return grade_t'(ONE_Q8);
        else if (xi < 40)
            return grade_t'(div_by_10((40 - xi) * ONE_Q8 + 5));
        else
            return '0;
    endfunction

    function automatic grade_t grade_normal(input logic [LEVEL_W-1:0] x);
        int xi;
        xi = int'(x);
        if (xi <= 30)
            return '0;
        else if (xi < 50)
            return grade_t'(div_by_20((xi - 30) * ONE_Q8 + 10));
        else if (xi < 70)
            return grade_t'(div_by_20((70 - xi) * ONE_Q8 + 10));
        else
            return '0;
    endfunction

    function automatic grade_t grade_bright(input logic [LEVEL_W-1:0] x);
        int xi;
        xi = int'(x);
        if (xi <= 60)
            return '0;
        else if (xi < 70)
            return grade_t'(div_by_10((xi - 60) * ONE_Q8 + 5));
        else
            return grade_t'(ONE_Q8);
    endfunction

endpackage

FILE: hw/rtl/fzt_front.sv
// ============================================================================
// fzt_front
// Grading, rule weights, weighted sums and divider set-up, five stages.
// ============================================================================
module fzt_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [fzt_pkg::LEVEL_W-1:0]     top_level,
    input  logic [fzt_pkg::LEVEL_W-1:0]     bottom_level,
    output fzt_pkg::cell_t                  cell_out
);

    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    fzt_pkg::grade_t mt_reg [fzt_pkg::N_GRADES];
    fzt_pkg::grade_t mt_next [fzt_pkg::N_GRADES];
    fzt_pkg::grade_t mb_reg [fzt_pkg::N_GRADES];
    fzt_pkg::grade_t mb_next [fzt_pkg::N_GRADES];

    fzt_pkg::grade_t                r2_reg [fzt_pkg::N_RULES];
    fzt_pkg::grade_t                r2_next [fzt_pkg::N_RULES];
    logic [fzt_pkg::MAG_W-1:0]      mag_reg [fzt_pkg::N_RULES];
    logic [fzt_pkg::MAG_W-1:0]      mag_next [fzt_pkg::N_RULES];

    logic [fzt_pkg::PROD_W-1:0]     prod_reg [fzt_pkg::N_RULES];
    logic [fzt_pkg::PROD_W-1:0]     prod_next [fzt_pkg::N_RULES];
    logic [fzt_pkg::DEN_W-1:0]      den3_reg;
    logic [fzt_pkg::DEN_W-1:0]      den3_next;

    logic signed [fzt_pkg::NUM_W-1:0] num4_reg;
    logic signed [fzt_pkg::NUM_W-1:0] num4_next;
    logic [fzt_pkg::DEN_W-1:0]        den4_reg;

    fzt_pkg::cell_t                 cell_reg;
    fzt_pkg::cell_t                 cell_next;
    logic [fzt_pkg::NUM_W-1:0]      num_abs;

    assign valid_next = {valid_reg[3:0], in_valid};

    // stage 1: grading tables
    always_comb
    begin
        mt_next[0] = fzt_pkg::grade_dark(top_level);
        mt_next[1] = fzt_pkg::grade_normal(top_level);
        mt_next[2] = fzt_pkg::grade_bright(top_level);
        mb_next[0] = fzt_pkg::grade_dark(bottom_level);
        mb_next[1] = fzt_pkg::grade_normal(bottom_level);
        mb_next[2] = fzt_pkg::grade_bright(bottom_level);
    end

    // stage 2: rule weight and proposal magnitude
    always_comb
    begin
        for (int i = 0; i < fzt_pkg::N_GRADES; i++)
        begin
            for (int j = 0; j < fzt_pkg::N_GRADES; j++)
            begin
                r2_next[i*fzt_pkg::N_GRADES + j] = (mt_reg[i] < mb_reg[j]) ? mt_reg[i]
                                                                           : mb_reg[j];
            end
        end
        for (int k = 0; k < fzt_pkg::N_RULES; k++)
        begin
            mag_next[k] = fzt_pkg::MAG_W'(r2_next[k]) * fzt_pkg::MAG_W'(fzt_pkg::MAG_SLOPE)
                        + fzt_pkg::MAG_W'(fzt_pkg::MAG_BASE);
        end
    end

    // stage 3: products and weight total
    always_comb
    begin
        den3_next = '0;
        for (int k = 0; k < fzt_pkg::N_RULES; k++)
        begin
            prod_next[k] = fzt_pkg::PROD_W'(r2_reg[k]) * fzt_pkg::PROD_W'(mag_reg[k]);
            den3_next    = den3_next + fzt_pkg::DEN_W'(r2_reg[k]);
        end
    end

    // stage 4: signed numerator
    always_comb
    begin
        num4_next = '0;
        for (int i = 0; i < fzt_pkg::N_GRADES; i++)
        begin
            for (int j = 0; j < fzt_pkg::N_GRADES; j++)
            begin
                case (fzt_pkg::RULE_ACTION[i][j])
                    fzt_pkg::ACT_CW:
                        num4_next = num4_next
                                  + signed'(fzt_pkg::NUM_W'(prod_reg[i*fzt_pkg::N_GRADES + j]));
                    fzt_pkg::ACT_CCW:
                        num4_next = num4_next
                                  - signed'(fzt_pkg::NUM_W'(prod_reg[i*fzt_pkg::N_GRADES + j]));
                    default:
                        num4_next = num4_next;
                endcase
            end
        end
    end

    // stage 5: magnitude plus half divisor, divisor aligned for the top quotient bit
    always_comb
    begin
        num_abs         = num4_reg[fzt_pkg::NUM_W-1] ? fzt_pkg::NUM_W'(-num4_reg)
                                                     : fzt_pkg::NUM_W'(num4_reg);
        cell_next.valid = valid_reg[3];
        cell_next.zero  = (den4_reg == '0);
        cell_next.neg   = num4_reg[fzt_pkg::NUM_W-1];
        cell_next.rem   = num_abs[fzt_pkg::REM_W-1:0]
                        + fzt_pkg::REM_W'(den4_reg >> 1);
        cell_next.dsh   = {den4_reg, {(fzt_pkg::Q_W-1){1'b0}}};
        cell_next.quo   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mt_reg    <= mt_next;
            mb_reg    <= mb_next;
            r2_reg    <= r2_next;
            mag_reg   <= mag_next;
            prod_reg  <= prod_next;
            den3_reg  <= den3_next;
            num4_reg  <= num4_next;
            den4_reg  <= den3_reg;
            cell_reg  <= cell_next;
        end
    end

    always_comb
    begin
        cell_out       = cell_reg;
        cell_out.valid = valid_reg[4];
    end

endmodule

FILE: hw/rtl/fzt_div_cell.sv
// ============================================================================
// fzt_div_cell
// One restoring-division cell: settles one quotient bit per beat and hands
// the partial remainder and halved divisor to the next cell.
// ============================================================================
module fzt_div_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  fzt_pkg::cell_t  cell_in,
    output fzt_pkg::cell_t  cell_out
);

    logic           valid_reg;
    fzt_pkg::cell_t data_reg;
    fzt_pkg::cell_t data_next;
    logic           take;

    always_comb
    begin
        take           = (cell_in.rem >= cell_in.dsh);
        data_next      = cell_in;
        data_next.rem  = take ? cell_in.rem - cell_in.dsh : cell_in.rem;
        data_next.dsh  = cell_in.dsh >> 1;
        data_next.quo  = {cell_in.quo[fzt_pkg::Q_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

FILE: hw/rtl/fuzzy_tracker_drive.sv
// ============================================================================
// fuzzy_tracker_drive
// Two-input fuzzy tracker controller: light levels in, signed motor drive out.
// ============================================================================
// Usage:
//   s_axis carries one sample per beat: top and bottom light level (0..100).
//   m_axis returns one drive value per sample, in sample order, signed in
//   1/256 units (-2560..2560, positive is clockwise).
//   From the accepting edge to m_axis_tvalid a sample passes the five
//   front stages (grading, rule weights, products, sums, set-up), twelve
//   divider cells that each settle one quotient bit, and the output register.
//   Throughput is one sample per cycle while m_axis is not stalled; the divider row is fully pipelined.
//   The whole pipe advances together whenever the output register is empty
//   or being taken, so s_axis_tready is low only while a result sits in the
//   output register and m_axis_tready is low. Nothing is lost while stalled;
//   bubbles in the pipe are not squeezed out.
//   Reset clears all valid flags; the data registers are not reset and there is
//   no configuration, so the block is ready in the first cycle after reset.
// ============================================================================
module fuzzy_tracker_drive
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fzt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // top_level[6:0], bottom_level[13:7]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fzt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata    // drive[12:0]
);

    logic                                   en;
    fzt_pkg::cell_t                         chain [fzt_pkg::Q_W+1];
    fzt_pkg::cell_t                         last;
    logic                                   out_valid_reg;
    logic [fzt_pkg::DRIVE_W-1:0]            drive_reg;
    logic [fzt_pkg::DRIVE_W-1:0]            drive_next;
    logic [fzt_pkg::DRIVE_W-1:0]            quo_ext;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    fzt_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .top_level    (s_axis_tdata[fzt_pkg::LEVEL_W-1:0]),
        .bottom_level (s_axis_tdata[2*fzt_pkg::LEVEL_W-1:fzt_pkg::LEVEL_W]),
        .cell_out     (chain[0])
    );

    for (genvar g = 0; g < fzt_pkg::Q_W; g++)
    begin : g_cell
        fzt_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    assign last = chain[fzt_pkg::Q_W];

    always_comb
    begin
        quo_ext = fzt_pkg::DRIVE_W'(last.quo);
        if (last.zero)
            drive_next = '0;
        else if (last.neg)
            drive_next = -quo_ext;
        else
            drive_next = quo_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drive_reg <= drive_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = fzt_pkg::OUT_TDATA_W'(drive_reg);

endmodule

FILE: hw/rtl/fzt_checker.sv
// ============================================================================
// fzt_checker
// Port-level checks on the fuzzy tracker drive, bound to the top level.
// ============================================================================
module fzt_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [fzt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [fzt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic signed [fzt_pkg::DRIVE_W-1:0] drive;
    assign drive = signed'(m_axis_tdata[fzt_pkg::DRIVE_W-1:0]);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("m_axis beat dropped or changed while stalled");

    // input side only stalls behind a waiting result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("s_axis_tready low with output free");

    // drive stays within the proposal range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> drive >= -13'sd2560 && drive <= 13'sd2560)
        else $error("drive out of range");

    // upper pad bits of the result beat are zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[fzt_pkg::OUT_TDATA_W-1:fzt_pkg::DRIVE_W] == '0)
        else $error("m_axis_tdata padding not zero");

endmodule

bind fuzzy_tracker_drive fzt_checker u_fzt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
